FILE: rtl/csp_pkg.sv
// Shared types and constants for the CSV sample parser and window buffer.
package csp_pkg;

  // Ring of stored Q.8 samples
  localparam int RING_DEPTH  = 600;
  localparam int WARMUP_FILL = 200;
  localparam int RING_AW     = $clog2(RING_DEPTH);

  // Field widths at the ports
  localparam int POS_W  = 10;
  localparam int WIN_W  = 10;
  localparam int CHAR_W = 8;
  localparam int AXIS_W = 21;

  // Width that holds a ring index plus a window offset
  localparam int WIDE_W = ((POS_W > RING_AW) ? POS_W : RING_AW) + 1;

  // Window length after reset, kept as its remainder modulo the ring depth
  localparam int WIN_LEN_RESET = 384;
  localparam logic [RING_AW-1:0] WIN_SUB_RESET = RING_AW'(WIN_LEN_RESET % RING_DEPTH);

  // Decimal field accumulator
  localparam int MAG_W   = 16;
  localparam int MULW    = MAG_W + 4;
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(32768);
  localparam logic [MAG_W-1:0] POS_MAX   = MAG_W'(32767);

  // value*256/10 = value*128/5, divide by 5 through a reciprocal
  localparam int QIN_W   = MAG_W + 7;
  localparam int Q_SHIFT = 26;
  localparam int RECIP_W = 24;
  localparam logic [RECIP_W-1:0] Q_RECIP = RECIP_W'(13421773);
  localparam int PROD_W  = Q_SHIFT + AXIS_W;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  // Operations
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Field slots within a record (slot zero is the sequence number)
  localparam logic [1:0] FIELD_X = 2'd1;
  localparam logic [1:0] FIELD_Y = 2'd2;
  localparam logic [1:0] FIELD_Z = 2'd3;

  // Write steps of a record in the back end
  localparam logic [1:0] STEP_X = 2'd0;
  localparam logic [1:0] STEP_Y = 2'd1;
  localparam logic [1:0] STEP_Z = 2'd2;

  // Decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    KIND_ABSORB = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_WINDOW = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_CHAR,
    CLS_CLOSE,
    CLS_READ
  } cls_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic [RING_AW-1:0]       win_off;
  } entry_t;

endpackage

FILE: rtl/csp_front.sv
// Front end: character parsing, field scaling and transaction classification.
module csp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [csp_pkg::WIN_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [csp_pkg::CHAR_W-1:0]  char_code,
  input  logic [csp_pkg::POS_W-1:0]   window_pos,
  output logic                        push,
  output csp_pkg::entry_t             push_entry,
  input  logic                        q_full
);
  import csp_pkg::*;

  // Parser state
  logic [MAG_W-1:0]          field_magnitude;
  logic                      field_negative;
  logic                      field_stopped;
  logic                      field_started;
  logic [1:0]                field_count;
  logic signed [AXIS_W-1:0]  held_x_q;
  logic signed [AXIS_W-1:0]  held_y_q;
  logic [RING_AW-1:0]        win_sub;

  // Stage one register
  logic                      s1_valid;
  cls_t                      s1_cls;
  logic [1:0]                s1_field;
  logic                      s1_neg;
  logic [MAG_W-1:0]          s1_abs;
  logic [RING_AW-1:0]        s1_posm;

  logic                      load;
  logic                      accept;
  logic                      is_digit;
  logic                      is_minus;
  logic                      is_sep;
  logic [MULW-1:0]           mag_ext;
  logic [MULW-1:0]           mag_prod;
  logic [MAG_W-1:0]          mag_sat;
  logic [MAG_W-1:0]          close_abs;
  logic [WIDE_W-1:0]         pos_wide;
  logic [RING_AW-1:0]        posm;
  logic [WIDE_W-1:0]         cfg_wide;
  logic [QIN_W-1:0]          q_in;
  logic [PROD_W-1:0]         prod;
  logic signed [AXIS_W-1:0]  q_mag;
  logic signed [AXIS_W-1:0]  q_val;
  logic [WIDE_W-1:0]         off_raw;
  logic [RING_AW-1:0]        win_off;

  assign load     = !s1_valid || !q_full;
  assign accept   = in_valid && load;
  assign in_stall = !load;
  assign push     = s1_valid && !q_full;

  always_comb begin
    is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_minus  = (char_code == CH_MINUS);
    is_sep    = (char_code == CH_COMMA) || (char_code == CH_NL);
    mag_ext   = MULW'(field_magnitude);
    mag_prod  = (mag_ext << 3) + (mag_ext << 1) + MULW'(char_code[3:0]);
    mag_sat   = (mag_prod > MULW'(MAG_LIMIT)) ? MAG_LIMIT : mag_prod[MAG_W-1:0];
    close_abs = field_negative ? field_magnitude :
                ((field_magnitude > POS_MAX) ? POS_MAX : field_magnitude);
    pos_wide  = WIDE_W'(window_pos);
    posm      = (pos_wide >= WIDE_W'(RING_DEPTH)) ?
                RING_AW'(pos_wide - WIDE_W'(RING_DEPTH)) : RING_AW'(pos_wide);
    cfg_wide  = WIDE_W'(cfg_data);
  end

  // Stage two: scale the closed field, floor(value*128/5)
  always_comb begin
    q_in     = QIN_W'({s1_abs, 7'b0}) + (s1_neg ? QIN_W'(4) : QIN_W'(0));
    prod     = PROD_W'(q_in) * PROD_W'(Q_RECIP);
    q_mag    = prod[PROD_W-1 -: AXIS_W];
    q_val    = s1_neg ? -q_mag : q_mag;
    off_raw  = WIDE_W'(s1_posm) + WIDE_W'(RING_DEPTH) - WIDE_W'(win_sub);
    win_off  = (off_raw >= WIDE_W'(RING_DEPTH)) ?
               RING_AW'(off_raw - WIDE_W'(RING_DEPTH)) : RING_AW'(off_raw);
  end

  always_comb begin
    push_entry.kind    = KIND_ABSORB;
    push_entry.x       = '0;
    push_entry.y       = '0;
    push_entry.z       = '0;
    push_entry.win_off = '0;
    unique case (s1_cls)
      CLS_READ: begin
        push_entry.kind    = KIND_WINDOW;
        push_entry.win_off = win_off;
      end
      CLS_CLOSE: begin
        if (s1_field == FIELD_Z) begin
          push_entry.kind = KIND_RECORD;
          push_entry.x    = held_x_q;
          push_entry.y    = held_y_q;
          push_entry.z    = q_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_magnitude <= '0;
      field_negative  <= 1'b0;
      field_stopped   <= 1'b0;
      field_started   <= 1'b0;
      field_count     <= '0;
      held_x_q        <= '0;
      held_y_q        <= '0;
      win_sub         <= WIN_SUB_RESET;
      s1_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_sub <= (cfg_wide >= WIDE_W'(RING_DEPTH)) ?
                   RING_AW'(cfg_wide - WIDE_W'(RING_DEPTH)) : RING_AW'(cfg_wide);
      end
      if (load) begin
        s1_valid <= in_valid;
      end
      if (accept && opcode == OP_CHAR) begin
        if (is_digit || is_minus) begin
          field_started <= 1'b1;
          if (!field_started && is_minus) begin
            field_negative <= 1'b1;
          end
          if (field_started && is_minus) begin
            field_stopped <= 1'b1;
          end
          if (is_digit && !field_stopped) begin
            field_magnitude <= mag_sat;
          end
        end else if (is_sep) begin
          field_magnitude <= '0;
          field_negative  <= 1'b0;
          field_stopped   <= 1'b0;
          field_started   <= 1'b0;
          field_count     <= field_count + 2'd1;
        end
      end
      if (push && s1_cls == CLS_CLOSE) begin
        if (s1_field == FIELD_X) begin
          held_x_q <= q_val;
        end
        if (s1_field == FIELD_Y) begin
          held_y_q <= q_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_field <= field_count;
      s1_neg   <= field_negative;
      s1_abs   <= close_abs;
      s1_posm  <= posm;
      if (opcode == OP_READ) begin
        s1_cls <= CLS_READ;
      end else if (is_sep) begin
        s1_cls <= CLS_CLOSE;
      end else begin
        s1_cls <= CLS_CHAR;
      end
    end
  end

endmodule

FILE: rtl/csp_queue.sv
// Short queue of classified transactions between the front and back ends.
module csp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  csp_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output csp_pkg::entry_t  head
);
  import csp_pkg::*;

  entry_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW + 1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: rtl/csp_back.sv
// Back end: sample ring writes, window reads and the result register.
module csp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  csp_pkg::entry_t                   head,
  output logic                              pop,
  input  logic                              out_stall,
  output logic                              out_valid,
  output csp_pkg::kind_t                    kind,
  output logic                              ready_res,
  output logic signed [csp_pkg::AXIS_W-1:0] axis_x,
  output logic signed [csp_pkg::AXIS_W-1:0] axis_y,
  output logic signed [csp_pkg::AXIS_W-1:0] axis_z,
  output logic signed [csp_pkg::AXIS_W-1:0] window_value
);
  import csp_pkg::*;

  logic signed [AXIS_W-1:0] ring [RING_DEPTH];
  logic signed [AXIS_W-1:0] mem_rdata;

  logic [RING_AW-1:0]       wp;
  logic [RING_AW-1:0]       wp_inc;
  logic                     wrapped;
  logic                     warming;
  logic [1:0]               step;

  logic                     p_valid;
  kind_t                    p_kind;
  logic                     p_ready;
  logic                     p_zero;
  logic signed [AXIS_W-1:0] p_x;
  logic signed [AXIS_W-1:0] p_y;
  logic signed [AXIS_W-1:0] p_z;

  logic                     o_valid;
  kind_t                    o_kind;
  logic                     o_ready;
  logic signed [AXIS_W-1:0] o_x;
  logic signed [AXIS_W-1:0] o_y;
  logic signed [AXIS_W-1:0] o_z;
  logic signed [AXIS_W-1:0] o_win;

  logic                     o_load;
  logic                     p_advance;
  logic                     is_rec;
  logic                     rec_last;
  logic                     wr_en;
  logic                     rd_en;
  logic                     warm_done;
  logic signed [AXIS_W-1:0] wr_data;
  logic [WIDE_W-1:0]        idx_sum;
  logic [RING_AW-1:0]       idx;
  logic                     written;

  always_comb begin
    o_load    = !o_valid || !out_stall;
    p_advance = !p_valid || o_load;
    is_rec    = (head.kind == KIND_RECORD);
    rec_last  = (step == STEP_Z);
    wr_en     = head_valid && is_rec && (!rec_last || p_advance);
    pop       = head_valid && p_advance && (!is_rec || rec_last);
    rd_en     = pop && (head.kind == KIND_WINDOW);
    wp_inc    = (wp == RING_AW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
    warm_done = (int'(wp_inc) >= WARMUP_FILL);
    idx_sum   = WIDE_W'(wp) + WIDE_W'(head.win_off);
    idx       = (idx_sum >= WIDE_W'(RING_DEPTH)) ?
                RING_AW'(idx_sum - WIDE_W'(RING_DEPTH)) : RING_AW'(idx_sum);
    // entries are filled in order from zero, so the fill point marks what exists
    written   = wrapped || (idx < wp);
    unique case (step)
      STEP_X:  wr_data = head.x;
      STEP_Y:  wr_data = head.y;
      default: wr_data = head.z;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wp] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata <= ring[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      warming <= 1'b1;
      step    <= STEP_X;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wp <= wp_inc;
        if (wp == RING_AW'(RING_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
        if (rec_last) begin
          step <= STEP_X;
          if (warm_done) begin
            warming <= 1'b0;
          end
        end else begin
          step <= step + 2'd1;
        end
      end
      if (p_advance) begin
        p_valid <= pop;
      end
      if (o_load) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_kind  <= head.kind;
      p_x     <= head.x;
      p_y     <= head.y;
      p_z     <= head.z;
      p_zero  <= (head.kind != KIND_WINDOW) || warming || !written;
      p_ready <= (is_rec && rec_last) ? !(warming && !warm_done) : !warming;
    end
    if (o_load && p_valid) begin
      o_kind  <= p_kind;
      o_ready <= p_ready;
      o_x     <= p_x;
      o_y     <= p_y;
      o_z     <= p_z;
      o_win   <= p_zero ? '0 : mem_rdata;
    end
  end

  assign out_valid    = o_valid;
  assign kind         = o_kind;
  assign ready_res    = o_ready;
  assign axis_x       = o_x;
  assign axis_y       = o_y;
  assign axis_z       = o_z;
  assign window_value = o_win;

endmodule

FILE: rtl/csv_sample_parser_window_buffer.sv
// Top level of the CSV sample parser with its window ring buffer.
//
// Input channel (in_valid / in_stall): one transaction per item. opcode 0
// feeds char_code to the decimal parser; opcode 1 reads the window element
// at window_pos (0 is the oldest of the last window_length stored values).
// Output channel (out_valid / out_stall): exactly one result per input
// transaction, in order: kind 0 for an absorbed character, kind 1 when a
// fourth field closes and x, y, z are stored, kind 2 for a window read.
// Config channel (cfg_valid / cfg_ready): writes window_length; cfg_ready
// is always high. Write it only while no transaction is in flight.
// Each item passes the front stage register, the queue, then the back end's
// stage and result registers. Throughput: one item per cycle while in_stall
// is low. A record puts its three values into the single-port ring one per
// cycle, the last once the back end advances. The four-entry queue absorbs
// this hold on the back end when the sender leaves gaps, else in_stall rises.
// Reset: parser and ring fill state clear, window_length returns to 384 and
// warm-up restarts; unwritten ring entries read as zero via the fill mark.
// A stalled receiver holds the result register; the queue fills and then
// in_stall rises until results drain.
module csv_sample_parser_window_buffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csp_pkg::WIN_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [csp_pkg::CHAR_W-1:0]        char_code,
  input  logic [csp_pkg::POS_W-1:0]         window_pos,
  output logic                              out_valid,
  input  logic                              out_stall,
  output csp_pkg::kind_t                    kind,
  output logic                              ready_res,
  output logic signed [csp_pkg::AXIS_W-1:0] axis_x,
  output logic signed [csp_pkg::AXIS_W-1:0] axis_y,
  output logic signed [csp_pkg::AXIS_W-1:0] axis_z,
  output logic signed [csp_pkg::AXIS_W-1:0] window_value
);
  import csp_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // Config register sits in the front end; always take the write
  assign cfg_ready = 1'b1;

  // Parse and classify; hold the stage register when the queue is full
  csp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .char_code  (char_code),
    .window_pos (window_pos),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // Decouple the parser from ring writes and output stalls
  csp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Store records, serve window reads, drive the result register
  csp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .ready_res    (ready_res),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z),
    .window_value (window_value)
  );

endmodule

FILE: rtl/csp_checker.sv
// Port-level checks for the CSV sample parser, bound to the top level.
module csp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input csp_pkg::kind_t                    kind,
  input logic                              ready_res,
  input logic signed [csp_pkg::AXIS_W-1:0] axis_x,
  input logic signed [csp_pkg::AXIS_W-1:0] axis_y,
  input logic signed [csp_pkg::AXIS_W-1:0] axis_z,
  input logic signed [csp_pkg::AXIS_W-1:0] window_value
);
  import csp_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(axis_x)
      && $stable(window_value))
    else $error("stalled result changed");

  a_absorb_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ABSORB |-> axis_x == '0 && axis_y == '0
      && axis_z == '0 && window_value == '0)
    else $error("absorbed character carries a payload");

  a_cold_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_WINDOW && !ready_res |-> window_value == '0)
    else $error("window read during warm-up returned data");

endmodule

bind csv_sample_parser_window_buffer csp_checker u_csp_checker (.*);

FILE: tb/csv_sample_parser_window_buffer_tb.sv
// Self-checking testbench for the CSV sample parser and its window ring buffer.
module csv_sample_parser_window_buffer_tb;
  import csp_pkg::*;

  localparam int NUM_DIRECTED    = 26;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 500000;

  // One result as the block reports it
  typedef struct {
    kind_t                    kind;
    logic                     ready;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic signed [AXIS_W-1:0] wv;
  } sample_result_t;

  // One directed transaction; typed rows carry the result to expect
  typedef struct packed {
    logic                     op;
    logic [CHAR_W-1:0]        ch;
    logic [POS_W-1:0]         pos;
    logic                     typed;
    kind_t                    kind;
    logic                     ready;
    logic signed [AXIS_W-1:0] x, y, z, wv;
  } dir_row_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [WIN_W-1:0]         cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic                     opcode     = OP_CHAR;
  logic [CHAR_W-1:0]        char_code  = '0;
  logic [POS_W-1:0]         window_pos = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  kind_t                    res_kind;
  logic                     ready_res;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;
  logic signed [AXIS_W-1:0] window_value;

  csv_sample_parser_window_buffer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .char_code    (char_code),
    .window_pos   (window_pos),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (res_kind),
    .ready_res    (ready_res),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z),
    .window_value (window_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed opening: reads before warm-up, character extremes, a record whose
  // x saturates negative, y saturates positive and z is a lone minus, then a
  // sequence field cut short by a later minus.
  dir_row_t dir_table [NUM_DIRECTED] = '{
    '{OP_READ, 8'h00,          10'd0,   1'b1, KIND_WINDOW, 1'b0, '0, '0, '0, '0},
    '{OP_READ, 8'hFF,          10'h3FF, 1'b1, KIND_WINDOW, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, 8'h00,          10'h3FF, 1'b1, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, 8'hFF,          10'd0,   1'b1, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_ZERO + 8'd4, 10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_COMMA,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_MINUS,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_COMMA,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NINE,        10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_COMMA,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_MINUS,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_NL,          10'd0,   1'b1, KIND_RECORD, 1'b0,
      AXIS_W'(-838861), AXIS_W'(838835), '0, '0},
    '{OP_CHAR, CH_ZERO + 8'd1, 10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_ZERO + 8'd2, 10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_MINUS,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_ZERO + 8'd7, 10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0},
    '{OP_CHAR, CH_COMMA,       10'd0,   1'b0, KIND_ABSORB, 1'b0, '0, '0, '0, '0}
  };

  // Per-phase window length, sender idle rate and receiver stall rate
  int phase_win   [NUM_PHASES] = '{600, 1, 1023, 0, 0};
  int phase_idle  [NUM_PHASES] = '{0, 73, 0, 21, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 73, 21, 0};

  logic [CHAR_W-1:0] noise_chars [4] = '{CH_COMMA, CH_NL, CH_MINUS, CH_ZERO + 8'd5};

  // Parser and ring state mirrored for prediction
  int             fld_mag;
  logic           fld_neg;
  logic           fld_stopped;
  logic           fld_started;
  logic [1:0]     fld_slot;
  int             held_x;
  int             held_y;
  int unsigned    wr_pos;
  logic           warming;
  int             stored_samples [RING_DEPTH];
  int unsigned    win_len;

  sample_result_t pending_results [$];
  int unsigned    mismatch_count;
  int unsigned    accepted_count;
  int             idle_pct;
  int             stall_pct = 0;
  logic           hold_req  = 1'b0;
  int             hold_left = 0;
  logic           hold_taken = 1'b0;
  int unsigned    cycle_count;

  // floor(v * 256 / 10): value/10 in Q.8
  function automatic int q8_tenth(int v);
    int n;
    n = v * 256;
    return (n >= 0) ? n / 10 : -((-n + 9) / 10);
  endfunction

  // Advance the mirrored state by one transaction and return its result
  task automatic parse_step(input logic op, input logic [CHAR_W-1:0] ch,
                            input logic [POS_W-1:0] pos, output sample_result_t r);
    int          value;
    int          q [3];
    int unsigned idx;
    logic        is_digit;
    r.kind = KIND_ABSORB;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    r.wv = '0;
    is_digit = (ch >= CH_ZERO && ch <= CH_NINE);
    if (op == OP_CHAR) begin
      if (is_digit || ch == CH_MINUS) begin
        if (!fld_started) begin
          fld_started = 1'b1;
          if (ch == CH_MINUS) fld_neg = 1'b1;
        end else if (ch == CH_MINUS) begin
          fld_stopped = 1'b1;
        end
        if (is_digit && !fld_stopped) begin
          value = fld_mag * 10 + (int'(ch) - int'(CH_ZERO));
          fld_mag = (value > 32768) ? 32768 : value;
        end
      end else if (ch == CH_COMMA || ch == CH_NL) begin
        value = fld_neg ? -fld_mag : ((fld_mag > 32767) ? 32767 : fld_mag);
        fld_mag = 0;
        fld_neg = 1'b0;
        fld_stopped = 1'b0;
        fld_started = 1'b0;
        if (fld_slot == FIELD_X) held_x = value;
        if (fld_slot == FIELD_Y) held_y = value;
        if (fld_slot == FIELD_Z) begin
          q = '{q8_tenth(held_x), q8_tenth(held_y), q8_tenth(value)};
          for (int k = 0; k < 3; k++) begin
            stored_samples[wr_pos] = q[k];
            wr_pos = (wr_pos + 1) % RING_DEPTH;
          end
          if (warming && wr_pos >= WARMUP_FILL) warming = 1'b0;
          r.kind = KIND_RECORD;
          r.x = AXIS_W'(q[0]);
          r.y = AXIS_W'(q[1]);
          r.z = AXIS_W'(q[2]);
        end
        // slot three wraps back to the sequence number
        fld_slot = fld_slot + 2'd1;
      end
    end else begin
      r.kind = KIND_WINDOW;
      if (!warming) begin
        idx = (wr_pos + pos) % RING_DEPTH;
        idx = (idx + RING_DEPTH - win_len % RING_DEPTH) % RING_DEPTH;
        r.wv = AXIS_W'(stored_samples[idx]);
      end
    end
    r.ready = !warming;
  endtask

  // Offer one transaction, hold it until accepted, then log its prediction
  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    sample_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    window_pos <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_step(op, ch, pos, r);
    pending_results.push_back(r);
    accepted_count++;
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_CHAR, ch, POS_W'($urandom));
  endtask

  // Emit one decimal field of random shape, closed by sep
  task automatic send_field(input logic [CHAR_W-1:0] sep);
    int shape;
    int ndig;
    shape = $urandom_range(99);
    if (shape < 45) begin
      if ($urandom_range(2) == 0) send_char(CH_MINUS);
    end else begin
      if ($urandom_range(1) == 0) send_char(CH_MINUS);
      ndig = (shape < 70) ? 1 : (shape < 90) ? $urandom_range(5, 2) : $urandom_range(8, 6);
      for (int i = 0; i < ndig; i++) begin
        if ($urandom_range(19) == 0) send_char({1'b1, 7'($urandom)});
        if (shape >= 95 && i == ndig / 2) send_char(CH_MINUS);
        send_char(CH_ZERO + CHAR_W'($urandom_range(9)));
      end
    end
    send_char(sep);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_window_length(input logic [WIN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_len = len;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stall, or one long hold-off counted down here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_OFF_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    sample_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: kind %0d", $time, res_kind);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(res_kind));
        check_field("ready_res", 32'(want.ready), 32'(ready_res));
        check_field("axis_x", 32'(want.x), 32'(axis_x));
        check_field("axis_y", 32'(want.y), 32'(axis_y));
        check_field("axis_z", 32'(want.z), 32'(axis_z));
        check_field("window_value", 32'(want.wv), 32'(window_value));
      end
    end
  end

  // Watchdog: end the run if it overstays the cycle budget
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sample_result_t typed_want;
    int             pick;
    logic           hold_asked;
    logic           pause_done;
    logic [WIN_W-1:0] len;
    fld_mag = 0;
    fld_neg = 1'b0;
    fld_stopped = 1'b0;
    fld_started = 1'b0;
    fld_slot = '0;
    held_x = 0;
    held_y = 0;
    wr_pos = 0;
    warming = 1'b1;
    win_len = WIN_LEN_RESET;
    mismatch_count = 0;
    idle_pct = 0;
    hold_asked = 1'b0;
    pause_done = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, window length still at its reset value
    foreach (dir_table[i]) begin
      send_item(dir_table[i].op, dir_table[i].ch, dir_table[i].pos);
      if (dir_table[i].typed) begin
        typed_want.kind  = dir_table[i].kind;
        typed_want.ready = dir_table[i].ready;
        typed_want.x     = dir_table[i].x;
        typed_want.y     = dir_table[i].y;
        typed_want.z     = dir_table[i].z;
        typed_want.wv    = dir_table[i].wv;
        pending_results[pending_results.size() - 1] = typed_want;
      end
    end

    // Random phases: mostly well-formed records, some reads, some noise
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      idle_pct = phase_idle[ph];
      stall_pct <= phase_stall[ph];
      len = (ph == NUM_PHASES - 1) ? WIN_W'($urandom_range(599, 2)) : WIN_W'(phase_win[ph]);
      write_window_length(len);
      accepted_count = 0;
      while (accepted_count < ITEMS_PER_PHASE) begin
        // Starve the output for a long stretch while input keeps coming
        if (ph == 0 && !hold_asked && accepted_count >= 20) begin
          hold_req <= 1'b1;
          hold_asked = 1'b1;
        end
        // Let the pipeline run dry once mid-phase
        if (ph == NUM_PHASES - 1 && !pause_done && accepted_count >= ITEMS_PER_PHASE / 2) begin
          wait_drained();
          pause_done = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 72) begin
          repeat (3) send_field(CH_COMMA);
          send_field($urandom_range(1) ? CH_COMMA : CH_NL);
        end else if (pick < 88) begin
          if (win_len >= 1 && win_len <= RING_DEPTH && $urandom_range(4) != 0)
            send_item(OP_READ, CHAR_W'($urandom), POS_W'($urandom_range(win_len - 1)));
          else
            send_item(OP_READ, CHAR_W'($urandom), POS_W'($urandom));
        end else begin
          repeat ($urandom_range(4, 1))
            send_char($urandom_range(1) ? CHAR_W'($urandom) : noise_chars[$urandom_range(3)]);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
